FILE: sv/bsc_pkg.sv
// Package for the banker's safety check unit: sizes, action codes, payload structs.
// No dependencies; every other file imports it.
package bsc_pkg;

  localparam int unsigned MaxProc    = 16;
  localparam int unsigned MaxRes     = 16;
  localparam int unsigned AmtBits    = 16;
  localparam int unsigned ProcBits   = 4;
  localparam int unsigned ResBits    = 4;
  localparam int unsigned CntBits    = 5;
  localparam int unsigned WorkBits   = 21;
  localparam int unsigned AddrBits   = ProcBits + ResBits;
  localparam int unsigned CfgIdxBits = 2;

  typedef enum logic [1:0] {
    ActLoadAlloc = 2'd0,
    ActLoadMax   = 2'd1,
    ActLoadAvail = 2'd2,
    ActRun       = 2'd3
  } action_e;

  localparam logic [CfgIdxBits-1:0] CfgProcCount = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgResCount  = 2'd1;

  typedef struct packed {
    logic [1:0]          action;
    logic [ProcBits-1:0] process_index;
    logic [ResBits-1:0]  resource_index;
    logic [AmtBits-1:0]  amount;
  } in_item_t;

  typedef struct packed {
    logic                safe;
    logic [ProcBits-1:0] sequence_process;
    logic                last;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StInit,
    StProcStart,
    StRead,
    StCheck,
    StAddRead,
    StAddWrite,
    StNextProc,
    StEmit,
    StUnsafe
  } state_e;

  // Request from the sequencer to the table memories.
  typedef struct packed {
    logic                wr_alloc;
    logic                wr_max;
    logic [AddrBits-1:0] addr;
    logic [AmtBits-1:0]  wdata;
  } tbl_req_t;

  // Clamp a configured count into 1..top.
  function automatic logic [CntBits-1:0] clamp_count(logic [CntBits-1:0] v,
                                                     logic [CntBits-1:0] top);
    logic [CntBits-1:0] r;
    r = v;
    if (v == '0) r = CntBits'(1);
    else if (v > top) r = top;
    return r;
  endfunction

endpackage

FILE: sv/bankers_safety_check_unit.sv
// Top level of the banker's safety check unit: register file, vectors, sequencer.
// Depends on bsc_pkg and bsc_tables.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | in_data_i (in_item_t)
//  out     | output    | out_valid/out_stall | out_data_o (out_item_t)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
//
// A load writes its entry. A run copies avail into work, then each process visit
// skips a finished process, stops at the first resource whose need fails, or, if
// the need fits, walks the one table read port once for the check and once for
// the work update. Results leave via an output register, one per unstalled cycle.
// Reset clears counts to 1 and all control state; tables are undefined until written.
// A stall on the output holds the sequencer; no input is taken during a run.
module bankers_safety_check_unit
  import bsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data_i,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CntBits-1:0]    cfg_data_i
);

  state_e state_q, state_d;
  logic [CntBits-1:0]  pcount_q, rcount_q;
  logic [AmtBits-1:0]  avail_q [MaxRes];
  logic [WorkBits-1:0] work_q [MaxRes];
  logic [MaxProc-1:0]  fin_q;
  logic [ProcBits-1:0] order_q [MaxProc];
  logic [CntBits-1:0]  fcount_q;
  logic [ProcBits-1:0] proc_q;
  logic [ResBits-1:0]  res_q;
  logic                found_q;
  logic                fits_q;
  logic [CntBits-1:0]  emit_q;
  logic                ov_q;
  out_item_t           od_q;

  logic [CntBits-1:0] pc, rc;
  logic [AmtBits-1:0] alloc_rd, max_rd;
  tbl_req_t           req;
  logic               in_acc, out_free;
  logic               last_res, last_proc;
  logic signed [AmtBits+1:0] need;
  logic               need_over;
  logic [CntBits-1:0] emit_next;

  assign pc = clamp_count(pcount_q, CntBits'(MaxProc));
  assign rc = clamp_count(rcount_q, CntBits'(MaxRes));
  assign in_stall   = (state_q != StIdle);
  assign in_acc     = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign out_valid  = ov_q;
  assign out_data_o = od_q;
  assign out_free   = !ov_q || !out_stall;
  assign last_res  = ({1'b0, res_q} == rc - CntBits'(1));
  assign last_proc = ({1'b0, proc_q} == pc - CntBits'(1));
  assign need = $signed({2'b00, max_rd}) - $signed({2'b00, alloc_rd});
  // A negative need always fits, so the comparison keeps the sign of need.
  assign need_over = need > $signed({1'b0, work_q[res_q]});
  assign emit_next = emit_q + CntBits'(1);

  always_comb begin
    req.wr_alloc = in_acc && (in_data_i.action == ActLoadAlloc);
    req.wr_max   = in_acc && (in_data_i.action == ActLoadMax);
    req.wdata    = in_data_i.amount;
    if (state_q == StIdle) begin
      req.addr = {in_data_i.process_index, in_data_i.resource_index};
    end else begin
      req.addr = {proc_q, res_q};
    end
  end

  bsc_tables u_tables (
    .clk_i  (clk_i),
    .req_i  (req),
    .alloc_o(alloc_rd),
    .max_o  (max_rd)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:      if (in_acc && in_data_i.action == ActRun) state_d = StInit;
      StInit:      state_d = StProcStart;
      StProcStart: state_d = fin_q[proc_q] ? StNextProc : StRead;
      StRead:      state_d = StCheck;
      StCheck: begin
        if (!fits_q || need_over) begin
          state_d = StNextProc;
        end else if (last_res) begin
          state_d = StAddRead;
        end else begin
          state_d = StRead;
        end
      end
      StAddRead:   state_d = StAddWrite;
      StAddWrite:  state_d = last_res ? StNextProc : StAddRead;
      StNextProc: begin
        if (fcount_q == pc) state_d = StEmit;
        else if (last_proc) state_d = found_q ? StProcStart : StUnsafe;
        else state_d = StProcStart;
      end
      StEmit:      if (out_free && emit_next == pc) state_d = StIdle;
      StUnsafe:    if (out_free) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= CntBits'(1);
      rcount_q <= CntBits'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index_i == CfgProcCount) pcount_q <= cfg_data_i;
      else if (cfg_index_i == CfgResCount) rcount_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.action == ActLoadAvail) begin
      avail_q[in_data_i.resource_index] <= in_data_i.amount;
    end
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q    <= '0;
      fcount_q <= '0;
      proc_q   <= '0;
      res_q    <= '0;
      found_q  <= 1'b0;
      fits_q   <= 1'b0;
      emit_q   <= '0;
      ov_q     <= 1'b0;
      od_q     <= '0;
      for (int i = 0; i < MaxRes; i++) work_q[i] <= '0;
      for (int i = 0; i < MaxProc; i++) order_q[i] <= '0;
    end else begin
      if (ov_q && !out_stall) ov_q <= 1'b0;
      unique case (state_q)
        StInit: begin
          for (int i = 0; i < MaxRes; i++) work_q[i] <= WorkBits'(avail_q[i]);
          fin_q    <= '0;
          fcount_q <= '0;
          proc_q   <= '0;
          found_q  <= 1'b0;
          emit_q   <= '0;
        end
        StProcStart: begin
          res_q  <= '0;
          fits_q <= 1'b1;
        end
        StRead: ;
        StCheck: begin
          // The entry's need is compared one resource at a time.
          if (need_over) begin
            fits_q <= 1'b0;
          end else if (last_res) begin
            res_q <= '0;
          end else begin
            res_q <= res_q + ResBits'(1);
          end
        end
        StAddRead: ;
        StAddWrite: begin
          work_q[res_q] <= work_q[res_q] + WorkBits'(alloc_rd);
          if (last_res) begin
            fin_q[proc_q] <= 1'b1;
            order_q[fcount_q[ProcBits-1:0]] <= proc_q;
            fcount_q <= fcount_q + CntBits'(1);
            found_q  <= 1'b1;
          end else begin
            res_q <= res_q + ResBits'(1);
          end
        end
        StNextProc: begin
          if (last_proc) begin
            proc_q  <= '0;
            found_q <= 1'b0;
          end else begin
            proc_q <= proc_q + ProcBits'(1);
          end
        end
        StEmit: begin
          if (out_free) begin
            ov_q <= 1'b1;
            od_q.safe <= 1'b1;
            od_q.sequence_process <= order_q[emit_q[ProcBits-1:0]];
            od_q.last <= (emit_next == pc);
            emit_q <= emit_next;
          end
        end
        StUnsafe: begin
          if (out_free) begin
            ov_q <= 1'b1;
            od_q.safe <= 1'b0;
            od_q.sequence_process <= '0;
            od_q.last <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/bsc_tables.sv
// Allocation and maximum-claim tables: two synchronous memories with a registered read.
// Depends on bsc_pkg.
module bsc_tables
  import bsc_pkg::*;
(
  input  logic               clk_i,
  input  tbl_req_t           req_i,
  output logic [AmtBits-1:0] alloc_o,
  output logic [AmtBits-1:0] max_o
);

  logic [AmtBits-1:0] alloc_mem [MaxProc*MaxRes];
  logic [AmtBits-1:0] max_mem   [MaxProc*MaxRes];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_alloc) begin
      alloc_mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.wr_max) begin
      max_mem[req_i.addr] <= req_i.wdata;
    end
    alloc_o <= alloc_mem[req_i.addr];
    max_o   <= max_mem[req_i.addr];
  end

endmodule
